// ----- hdl/ttl_pkg.sv -----
// shared constants, ratio table and types for the thermistor table linearizer
package ttl_pkg;

   // field widths
   localparam int RES_W          = 20;
   localparam int NOM_W          = 17;
   localparam int TEMP_W         = 15;
   localparam int STAT_W         = 2;

   // fixed point setup
   localparam int TABLE_ENTRIES  = 21;
   localparam int TEMP_FRAC_BITS = 8;
   localparam int RATIO_FRAC     = 16;
   localparam int STEP_DEGC      = 5;
   localparam int RATIO_TOP      = 187859;

   localparam int RATIO_W = $clog2(RATIO_TOP + 1);
   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int SCALE   = STEP_DEGC << TEMP_FRAC_BITS;
   localparam int Q_W     = $clog2(SCALE + 1);
   localparam int NUM_W   = RATIO_W + Q_W;
   localparam int X_W     = RES_W + RATIO_FRAC;
   localparam int LIM_W   = NOM_W + RATIO_W;
   localparam int CMP_W   = (X_W > LIM_W) ? X_W : LIM_W;

   localparam logic [NOM_W-1:0] NOMINAL_RESET = NOM_W'(9411);
   localparam logic [LIM_W-1:0] LIM_RESET =
      LIM_W'(64'(9411) * 64'(RATIO_TOP + 1));
   localparam logic [TEMP_W-1:0] TEMP_LAST =
      TEMP_W'(64'(TABLE_ENTRIES - 1) * 64'(SCALE));

   // pipeline stage positions
   localparam int S_LOOK = RATIO_W + 1;
   localparam int S_DIFF = RATIO_W + 2;
   localparam int S_NUM  = RATIO_W + 3;
   localparam int S_OUT  = S_NUM + Q_W + 1;
   localparam int NS     = S_OUT + 1;

   typedef logic [RATIO_W-1:0] ratio_type;

   // resistance ratios at 0..100 degC, 16 fraction bits
   localparam ratio_type RATIO_TABLE [TABLE_ENTRIES] = '{
      18'd187859, 18'd150123, 18'd120835, 18'd97780, 18'd79652, 18'd65536,
      18'd54379,  18'd44981,  18'd37423,  18'd31467, 18'd26572, 18'd22394,
      18'd18974,  18'd16197,  18'd13882,  18'd11924, 18'd10276, 18'd8908,
      18'd7748,   18'd6776,   18'd5947
   };

   typedef enum logic [STAT_W-1:0] {
      STATUS_INSIDE = 2'd0,
      STATUS_COLD   = 2'd1,
      STATUS_HOT    = 2'd2
   } status_type;

endpackage

// ----- hdl/thermistor_table_linearizer.sv -----
// thermistor linearizer: ratio division, table search, interpolation pipeline
//
// Converts a measured NTC resistance into a Q7.8 temperature by dividing it by the
// nominal 25 degC resistance, locating the bracketing 5 degC table segment and
// interpolating. One transaction is taken per cycle while the output buffer has room.
// The pipeline holds the 18 one-bit restoring division steps that form the resistance
// ratio and the 11 steps of the interpolation division, each a pipeline stage. A
// two-entry output buffer lets requests keep flowing while one result waits. Ratios
// above the first entry (and a nominal value of zero) give 0 degC with the cold status,
// ratios below the last entry give 100 degC with the hot status. The nominal
// resistance may be written only while no transaction is in flight.
module thermistor_table_linearizer
   import ttl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NOM_W-1:0]  csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [RES_W-1:0]  req_resistance_ohms,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [TEMP_W-1:0] rsp_temperature,
   output logic [STAT_W-1:0] rsp_range_status
);

   // configuration: nominal value and the saturation limit derived from it
   logic [NOM_W-1:0] nominal_ff;
   logic [LIM_W-1:0] lim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff <= NOMINAL_RESET;
         lim_ff     <= LIM_RESET;
      end else if (csr_valid) begin
         nominal_ff <= csr_data;
         lim_ff     <= LIM_W'(csr_data) * LIM_W'(RATIO_TOP + 1);
      end
   end

   // pipeline control: everything moves while the output buffer has room
   logic [NS-1:0] vld_ff;
   logic [1:0]    cnt_ff;
   logic          en;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   // ratio division stages
   logic [NOM_W-1:0]   d1_rem_ff  [RATIO_W+1];
   logic [RATIO_W-1:0] d1_q_ff    [RATIO_W+1];
   logic               d1_cold_ff [RATIO_W+1];
   logic [X_W-1:0]     x;

   // entry: scale resistance, flag ratios above the first entry
   assign x = {req_resistance_ohms, RATIO_FRAC'(0)};

   always_ff @(posedge clock) begin
      if (en) begin
         d1_rem_ff[0]  <= NOM_W'(x >> RATIO_W);
         d1_q_ff[0]    <= x[RATIO_W-1:0];
         d1_cold_ff[0] <= (CMP_W'(x) >= CMP_W'(lim_ff));
      end
   end

   for (genvar j = 1; j <= RATIO_W; j++) begin : g_div1
      logic [NOM_W:0] t;
      logic           ge;

      // one restoring step per stage
      assign t  = {d1_rem_ff[j-1], d1_q_ff[j-1][RATIO_W-1]};
      assign ge = (t >= {1'b0, nominal_ff});

      always_ff @(posedge clock) begin
         if (en) begin
            d1_rem_ff[j]  <= ge ? NOM_W'(t - {1'b0, nominal_ff}) : NOM_W'(t);
            d1_q_ff[j]    <= {d1_q_ff[j-1][RATIO_W-2:0], ge};
            d1_cold_ff[j] <= d1_cold_ff[j-1];
         end
      end
   end

   // table search: count entries between the first and the last that are still >= ratio
   ratio_type        look_r_ff;
   logic [IDX_W-1:0] look_lo_ff;
   logic             look_cold_ff;
   logic             look_hot_ff;
   logic [IDX_W-1:0] lo_in;

   always_comb begin
      lo_in = '0;
      for (int i = 1; i < TABLE_ENTRIES - 1; i++) begin
         lo_in = lo_in + IDX_W'(RATIO_TABLE[i] >= d1_q_ff[RATIO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         look_r_ff    <= d1_q_ff[RATIO_W];
         look_lo_ff   <= lo_in;
         look_cold_ff <= d1_cold_ff[RATIO_W];
         look_hot_ff  <= (d1_q_ff[RATIO_W] < RATIO_TABLE[TABLE_ENTRIES-1]);
      end
   end

   // segment offset and segment width
   ratio_type        diff_ff;
   ratio_type        den_diff_ff;
   logic [IDX_W-1:0] diff_lo_ff;
   logic             diff_cold_ff;
   logic             diff_hot_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff      <= RATIO_TABLE[look_lo_ff] - look_r_ff;
         den_diff_ff  <= RATIO_TABLE[look_lo_ff] - RATIO_TABLE[look_lo_ff + IDX_W'(1)];
         diff_lo_ff   <= look_lo_ff;
         diff_cold_ff <= look_cold_ff;
         diff_hot_ff  <= look_hot_ff;
      end
   end

   // interpolation division stages, index 0 holds the rounded numerator
   logic [RATIO_W-1:0] d2_rem_ff  [Q_W+1];
   logic [Q_W-1:0]     d2_q_ff    [Q_W+1];
   ratio_type          d2_den_ff  [Q_W+1];
   logic [IDX_W-1:0]   d2_lo_ff   [Q_W+1];
   logic               d2_cold_ff [Q_W+1];
   logic               d2_hot_ff  [Q_W+1];
   logic [NUM_W-1:0]   num;

   assign num = NUM_W'(diff_ff) * NUM_W'(SCALE) + NUM_W'(den_diff_ff >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         d2_rem_ff[0]  <= num[NUM_W-1:Q_W];
         d2_q_ff[0]    <= num[Q_W-1:0];
         d2_den_ff[0]  <= den_diff_ff;
         d2_lo_ff[0]   <= diff_lo_ff;
         d2_cold_ff[0] <= diff_cold_ff;
         d2_hot_ff[0]  <= diff_hot_ff;
      end
   end

   for (genvar j = 1; j <= Q_W; j++) begin : g_div2
      logic [RATIO_W:0] t;
      logic             ge;

      assign t  = {d2_rem_ff[j-1], d2_q_ff[j-1][Q_W-1]};
      assign ge = (t >= {1'b0, d2_den_ff[j-1]});

      always_ff @(posedge clock) begin
         if (en) begin
            d2_rem_ff[j]  <= ge ? RATIO_W'(t - {1'b0, d2_den_ff[j-1]}) : RATIO_W'(t);
            d2_q_ff[j]    <= {d2_q_ff[j-1][Q_W-2:0], ge};
            d2_den_ff[j]  <= d2_den_ff[j-1];
            d2_lo_ff[j]   <= d2_lo_ff[j-1];
            d2_cold_ff[j] <= d2_cold_ff[j-1];
            d2_hot_ff[j]  <= d2_hot_ff[j-1];
         end
      end
   end

   // segment base plus fraction, saturation override
   logic [TEMP_W-1:0] out_temp_ff;
   status_type        out_status_ff;
   logic [TEMP_W-1:0] temp_in;
   status_type        status_in;

   always_comb begin
      if (d2_cold_ff[Q_W]) begin
         temp_in   = '0;
         status_in = STATUS_COLD;
      end else if (d2_hot_ff[Q_W]) begin
         temp_in   = TEMP_LAST;
         status_in = STATUS_HOT;
      end else begin
         temp_in   = TEMP_W'(32'(d2_lo_ff[Q_W]) * SCALE + 32'(d2_q_ff[Q_W]));
         status_in = STATUS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_temp_ff   <= temp_in;
         out_status_ff <= status_in;
      end
   end

   // two-entry output buffer
   logic [TEMP_W-1:0] head_temp_ff;
   status_type        head_status_ff;
   logic [TEMP_W-1:0] spare_temp_ff;
   status_type        spare_status_ff;
   logic              push;
   logic              pop;

   assign push = en && vld_ff[S_OUT];
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            head_temp_ff   <= spare_temp_ff;
            head_status_ff <= spare_status_ff;
         end else if (push) begin
            head_temp_ff   <= out_temp_ff;
            head_status_ff <= out_status_ff;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            head_temp_ff   <= out_temp_ff;
            head_status_ff <= out_status_ff;
         end else begin
            spare_temp_ff   <= out_temp_ff;
            spare_status_ff <= out_status_ff;
         end
      end
   end

   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_temperature  = head_temp_ff;
   assign rsp_range_status = head_status_ff;

endmodule

// ----- hdl/ttl_checker.sv -----
// port level checks for the thermistor table linearizer, bound to the top level
module ttl_checker
   import ttl_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [TEMP_W-1:0] rsp_temperature,
   input logic [STAT_W-1:0] rsp_range_status
);

   // cold results are pinned to zero degrees
   a_cold_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_range_status == STATUS_COLD) |-> (rsp_temperature == '0))
      else $error("cold transaction with nonzero temperature");

   // hot results are pinned to the last table temperature
   a_hot_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_range_status == STATUS_HOT) |-> (rsp_temperature == TEMP_LAST))
      else $error("hot transaction not at table top");

   // results never leave the table range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature <= TEMP_LAST))
      else $error("temperature beyond table range");

   // no result out of an empty pipeline after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_range_status))
      else $error("stalled result changed");

endmodule

bind thermistor_table_linearizer ttl_checker u_ttl_checker (.*);

// ----- verif/ttl_checker.sv -----
// checker for the thermistor linearizer: predicts each temperature and compares results
module ttl_scoreboard
   import ttl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [NOM_W-1:0]  csr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [RES_W-1:0]  req_resistance_ohms,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [TEMP_W-1:0] rsp_temperature,
   input  logic [STAT_W-1:0] rsp_range_status,
   output int                error_count,
   output int                pending_count
);

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      status_type        status;
   } reading_type;

   logic [NOM_W-1:0] nominal;
   reading_type      expected_readings[$];

   // temperature and status for one resistance at the current nominal value
   function automatic reading_type convert_resistance(logic [RES_W-1:0] ohms);
      reading_type      result;
      logic [63:0]      ratio;
      logic [63:0]      hi_entry;
      logic [63:0]      lo_entry;
      logic [63:0]      span;
      logic [63:0]      frac;
      int               seg;
      result.temperature = '0;
      result.status = STATUS_INSIDE;
      seg = 0;
      if (nominal == 0) begin
         result.status = STATUS_COLD;
         return result;
      end
      ratio = (64'(ohms) << RATIO_FRAC) / 64'(nominal);
      if (ratio > 64'(RATIO_TABLE[0])) begin
         result.status = STATUS_COLD;
      end else if (ratio <= 64'(RATIO_TABLE[TABLE_ENTRIES-1])) begin
         result.temperature = TEMP_W'((TABLE_ENTRIES - 1) * SCALE);
         if (ratio < 64'(RATIO_TABLE[TABLE_ENTRIES-1])) result.status = STATUS_HOT;
      end else begin
         // last segment whose upper ratio still covers the measured one
         for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
            if (64'(RATIO_TABLE[i]) >= ratio) seg = i;
            else break;
         end
         hi_entry = 64'(RATIO_TABLE[seg]);
         lo_entry = 64'(RATIO_TABLE[seg+1]);
         span = hi_entry - lo_entry;
         frac = ((hi_entry - ratio) * 64'(SCALE) + span / 2) / span;
         result.temperature = TEMP_W'(64'(seg * SCALE) + frac);
      end
      return result;
   endfunction

   assign pending_count = expected_readings.size();

   // track the register, predict on each request, compare on each result
   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (reset) begin
         nominal <= NOMINAL_RESET;
         error_count <= 0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) nominal <= csr_data;
         if (req_valid && req_ready)
            expected_readings.push_back(convert_resistance(req_resistance_ohms));
         if (rsp_valid && rsp_ready) begin
            got.temperature = rsp_temperature;
            got.status = status_type'(rsp_range_status);
            if (expected_readings.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("unexpected result temp=%0d status=%0d",
                           got.temperature, got.status);
            end else begin
               want = expected_readings.pop_front();
               if (got.temperature !== want.temperature || got.status !== want.status) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                              want.temperature, want.status, got.temperature, got.status);
               end
            end
         end
      end
   end

endmodule

// ----- verif/tb_thermistor_table_linearizer.sv -----
// top of the thermistor linearizer testbench: stimulus, receiver stalls and verdict
module tb_thermistor_table_linearizer;
   import ttl_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [NOM_W-1:0]  csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [RES_W-1:0]  req_resistance_ohms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [TEMP_W-1:0] rsp_temperature;
   logic [STAT_W-1:0] rsp_range_status;
   int                error_count;
   int                pending_count;
   bit                hold_rsp = 1'b0;

   always #2 clock = ~clock;

   thermistor_table_linearizer dut (.*);

   ttl_scoreboard checker_inst (.*);

   // random gap length, mostly short and now and then long
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // resistance giving a ratio near a table entry, offset by a given number of ohms
   function automatic logic [RES_W-1:0] near_entry(logic [NOM_W-1:0] nom, int idx, int offs);
      longint ohms;
      ohms = (longint'(RATIO_TABLE[idx]) * nom) >> RATIO_FRAC;
      ohms = ohms + offs;
      if (ohms < 0) ohms = 0;
      if (ohms > 1048575) ohms = 1048575;
      return RES_W'(ohms);
   endfunction

   // send one request transaction, valid stays up for a following one
   task automatic send_resistance(logic [RES_W-1:0] ohms, bit gaps);
      int idle;
      idle = gaps ? gap_length() : 0;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_resistance_ohms <= ohms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid after the last accepted request
   task automatic end_requests();
      req_valid <= 1'b0;
   endtask

   // wait for every result, let the pipeline drain, then write the register
   task automatic write_nominal(logic [NOM_W-1:0] value);
      end_requests();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // receiver ready pattern with optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_ready <= 1'b0;
         else if ($urandom_range(0, 9) < 3) begin
            rsp_ready <= 1'b0;
            repeat (gap_length() + 1) @(posedge clock);
            rsp_ready <= 1'b1;
         end else rsp_ready <= 1'b1;
      end
   end

   initial begin
      #4000000;
      $display("tb_thermistor_table_linearizer: FAIL");
      $finish;
   end

   initial begin
      logic [NOM_W-1:0] nom;
      int               cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset nominal, extremes, exact hits and out of range ratios
      nom = NOMINAL_RESET;
      send_resistance('0, 0);
      send_resistance('1, 0);
      send_resistance(RES_W'(nom), 0);
      for (int i = 0; i < TABLE_ENTRIES; i += 4) send_resistance(near_entry(nom, i, 0), 0);
      send_resistance(near_entry(nom, 0, 3), 0);
      send_resistance(near_entry(nom, TABLE_ENTRIES - 1, -3), 0);
      send_resistance(near_entry(nom, TABLE_ENTRIES - 1, 1), 0);
      // nominal 65536 gives exact hits on the first and last entries
      write_nominal(NOM_W'(65536));
      send_resistance(RES_W'(RATIO_TABLE[0]), 0);
      send_resistance(RES_W'(RATIO_TABLE[TABLE_ENTRIES-1]), 0);
      send_resistance(RES_W'(RATIO_TABLE[7]), 0);
      // zero nominal is treated as an infinite ratio
      write_nominal('0);
      send_resistance(RES_W'(5000), 0);
      send_resistance('1, 0);
      write_nominal('1);
      send_resistance('1, 0);
      send_resistance(RES_W'(1000), 0);

      // random phases across several register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: nom = NOM_W'(1000);
            1: nom = NOM_W'(100000);
            2: nom = NOM_W'($urandom_range(1, 131071));
            default: nom = NOM_W'($urandom_range(1000, 100000));
         endcase
         write_nominal(nom);
         // long receiver hold-off while requests keep coming, so the input stalls
         if (phase == 1) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  cycles = 0;
                  while (cycles < 200) begin
                     @(posedge clock);
                     cycles++;
                  end
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < 150; n++) begin
            case ($urandom_range(0, 9))
               0: send_resistance(RES_W'($urandom()), 1);
               1: send_resistance(RES_W'($urandom_range(0, 3)), 1);
               2: send_resistance(RES_W'(1048575 - $urandom_range(0, 3)), 1);
               default: send_resistance(near_entry(nom, $urandom_range(0, TABLE_ENTRIES - 1),
                                                   $urandom_range(0, 400) - 200), 1);
            endcase
            // sender pause until everything has come back
            if (n == 75) begin
               end_requests();
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
         end
      end

      end_requests();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("tb_thermistor_table_linearizer: PASS");
      else $display("tb_thermistor_table_linearizer: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/ttl_pkg.sv
hdl/thermistor_table_linearizer.sv
hdl/ttl_checker.sv
verif/ttl_checker.sv
verif/tb_thermistor_table_linearizer.sv
